FILE: src/isgd_pkg.sv
// Shared types, constants and register map of the IMU strum gesture detector.
package isgd_pkg;

	// Queue sizes
	localparam int QueueDepthDef = 4;
	localparam int OutDepthDef   = 8;

	// Configuration port
	localparam int CfgAddrW = 5;
	localparam int CfgDataW = 32;

	// Register reset values
	localparam logic        [31:0] MagThreshRst   = 32'd650000000;
	localparam logic        [14:0] GxLimitRst     = 15'd20000;
	localparam logic signed [15:0] AxFloorRst     = -16'sd6000;
	localparam logic        [14:0] GzTrigRst      = 15'd10000;
	localparam logic        [14:0] GyTrigRst      = 15'd5000;
	localparam logic        [15:0] ReleaseBandRst = 16'd4000;
	localparam logic signed [15:0] GzBiasRst      = 16'sd416;
	localparam logic signed [15:0] GxBiasRst      = -16'sd1000;

	// Palm mute arming margins
	localparam logic signed [16:0] MuteGxExtra = 17'sd3500;
	localparam logic signed [15:0] MuteGzCeil  = 16'sd5000;

	// Velocity map: floor((peak - VelMinMag) * 127 / VelSpan)
	localparam logic [31:0] VelMinMag = 32'd800000000;
	localparam logic [31:0] VelMaxMag = 32'd2500000000;
	localparam logic [30:0] VelSpan   = 31'd1700000000;
	localparam logic [6:0]  VelTop    = 7'd127;
	// floor(127 * 2^40 / VelSpan); the estimate is low by at most one
	localparam int          VelShift  = 40;
	localparam logic [16:0] VelRecip  = 17'd82139;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_DOWN = 2'd1,
		MODE_UP   = 2'd2,
		MODE_MUTE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MAG_THRESH   = 3'd0,
		REG_GX_LIMIT     = 3'd1,
		REG_AX_FLOOR     = 3'd2,
		REG_GZ_TRIGGER   = 3'd3,
		REG_GY_TRIGGER   = 3'd4,
		REG_RELEASE_BAND = 3'd5,
		REG_GZ_BIAS      = 3'd6,
		REG_GX_BIAS      = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        [31:0] magnitude_threshold;
		logic        [14:0] gx_limit;
		logic signed [15:0] ax_floor;
		logic        [14:0] gz_trigger;
		logic        [14:0] gy_trigger;
		logic        [15:0] release_band;
		logic signed [15:0] gz_bias;
		logic signed [15:0] gx_bias;
	} cfg_t;

	// Classified sample handed from front to back
	typedef struct packed {
		mode_t       gesture;
		logic [31:0] peak;
	} mid_t;

	// Finished result
	typedef struct packed {
		logic [1:0] gesture;
		logic [6:0] velocity;
	} res_t;

endpackage

FILE: src/imu_strum_gesture_detector_top.sv
// Top level of the IMU strum gesture detector: register file, queues and the two halves.
//
// Usage
//   Samples enter on a queue-style port: a transaction happens at a clock edge with push
//   high and full low, carrying accel_x, gyro_x, gyro_y and gyro_z (signed 16 bits).
//   Every sample yields exactly one result transaction, in order: gesture (0 none,
//   1 down strum, 2 up strum, 3 palm mute) and strike_velocity (0-127, nonzero only for
//   a finished swing). A result is on the ports while empty is low and is taken at an
//   edge with pop high and empty low.
//   A sample passes the front stages, the middle queue and the back stages before empty
//   falls for its result. Throughput is one sample per cycle while full is low; the front
//   accepts the next sample while results still wait, set by the front's gesture state update.
//   Thresholds, bias values and the release band are written over the APB port at
//   byte address 4*index; pready is tied high and reads return the register value.
//   Write them only while no sample is in flight.
//   Reset (arst_n low) returns the state machine to idle with peak zero, empties both
//   queues and loads the register defaults. When the receiver stops popping, results
//   collect in the output queue, the back end holds the middle queue, and full rises
//   once the front's credit runs out; nothing is dropped.
module imu_strum_gesture_detector_top #(
	parameter int QueueDepth = isgd_pkg::QueueDepthDef,
	parameter int OutDepth   = isgd_pkg::OutDepthDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample channel
	input  logic                          push,
	output logic                          full,
	input  logic signed [15:0]            accel_x,
	input  logic signed [15:0]            gyro_x,
	input  logic signed [15:0]            gyro_y,
	input  logic signed [15:0]            gyro_z,
	// result channel
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    gesture,
	output logic [6:0]                    strike_velocity,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [isgd_pkg::CfgAddrW-1:0] paddr,
	input  logic [isgd_pkg::CfgDataW-1:0] pwdata,
	output logic [isgd_pkg::CfgDataW-1:0] prdata,
	output logic                          pready
);

	isgd_pkg::cfg_t     cfg_q;
	isgd_pkg::reg_idx_t reg_idx;
	logic               cfg_wr;

	logic           mid_push, mid_pop, mid_empty;
	isgd_pkg::mid_t mid_wr, mid_rd;

	logic           out_push, out_pop;
	isgd_pkg::res_t out_wr, out_rd;

	// Register file: word addressed, low two address bits ignored
	assign pready  = 1'b1;
	assign reg_idx = isgd_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magnitude_threshold <= isgd_pkg::MagThreshRst;
			cfg_q.gx_limit            <= isgd_pkg::GxLimitRst;
			cfg_q.ax_floor            <= isgd_pkg::AxFloorRst;
			cfg_q.gz_trigger          <= isgd_pkg::GzTrigRst;
			cfg_q.gy_trigger          <= isgd_pkg::GyTrigRst;
			cfg_q.release_band        <= isgd_pkg::ReleaseBandRst;
			cfg_q.gz_bias             <= isgd_pkg::GzBiasRst;
			cfg_q.gx_bias             <= isgd_pkg::GxBiasRst;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				isgd_pkg::REG_MAG_THRESH:   cfg_q.magnitude_threshold <= pwdata;
				isgd_pkg::REG_GX_LIMIT:     cfg_q.gx_limit            <= pwdata[14:0];
				isgd_pkg::REG_AX_FLOOR:     cfg_q.ax_floor            <= pwdata[15:0];
				isgd_pkg::REG_GZ_TRIGGER:   cfg_q.gz_trigger          <= pwdata[14:0];
				isgd_pkg::REG_GY_TRIGGER:   cfg_q.gy_trigger          <= pwdata[14:0];
				isgd_pkg::REG_RELEASE_BAND: cfg_q.release_band        <= pwdata[15:0];
				isgd_pkg::REG_GZ_BIAS:      cfg_q.gz_bias             <= pwdata[15:0];
				isgd_pkg::REG_GX_BIAS:      cfg_q.gx_bias             <= pwdata[15:0];
			endcase
		end
	end

	// Read back: sign-extend the signed registers
	always_comb begin
		unique case (reg_idx)
			isgd_pkg::REG_MAG_THRESH:   prdata = cfg_q.magnitude_threshold;
			isgd_pkg::REG_GX_LIMIT:     prdata = {17'd0, cfg_q.gx_limit};
			isgd_pkg::REG_AX_FLOOR:     prdata = {{16{cfg_q.ax_floor[15]}}, cfg_q.ax_floor};
			isgd_pkg::REG_GZ_TRIGGER:   prdata = {17'd0, cfg_q.gz_trigger};
			isgd_pkg::REG_GY_TRIGGER:   prdata = {17'd0, cfg_q.gy_trigger};
			isgd_pkg::REG_RELEASE_BAND: prdata = {16'd0, cfg_q.release_band};
			isgd_pkg::REG_GZ_BIAS:      prdata = {{16{cfg_q.gz_bias[15]}}, cfg_q.gz_bias};
			isgd_pkg::REG_GX_BIAS:      prdata = {{16{cfg_q.gx_bias[15]}}, cfg_q.gx_bias};
		endcase
	end

	// Front: classify samples and advance the gesture state
	isgd_front #(
		.QueueDepth(QueueDepth)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.accel_x  (accel_x),
		.gyro_x   (gyro_x),
		.gyro_y   (gyro_y),
		.gyro_z   (gyro_z),
		.cfg      (cfg_q),
		.mid_push (mid_push),
		.mid_data (mid_wr),
		.mid_pop  (mid_pop)
	);

	// Decoupling queue between front and back
	isgd_fifo #(
		.Width($bits(isgd_pkg::mid_t)),
		.Depth(QueueDepth)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_wr),
		.rd_en   (mid_pop),
		.rd_data (mid_rd),
		.empty   (mid_empty)
	);

	// Back: velocity mapping
	isgd_back #(
		.OutDepth(OutDepth)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_data  (mid_rd),
		.mid_pop   (mid_pop),
		.out_push  (out_push),
		.out_data  (out_wr),
		.out_pop   (out_pop)
	);

	// Result queue; hold the oldest result on the ports
	assign out_pop = pop & ~empty;

	isgd_fifo #(
		.Width($bits(isgd_pkg::res_t)),
		.Depth(OutDepth)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_wr),
		.rd_en   (out_pop),
		.rd_data (out_rd),
		.empty   (empty)
	);

	assign gesture         = out_rd.gesture;
	assign strike_velocity = out_rd.velocity;

endmodule

FILE: src/isgd_fifo.sv
// Small synchronous queue with occupancy count; writers never overrun it (credit controlled).
module isgd_fifo #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [Width-1:0] wr_data,
	input  logic             rd_en,
	output logic [Width-1:0] rd_data,
	output logic             empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/isgd_front.sv
// Front end: sample intake, squared gyro magnitude and the gesture state machine.
module isgd_front #(
	parameter int QueueDepth = isgd_pkg::QueueDepthDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	input  isgd_pkg::cfg_t     cfg,
	output logic               mid_push,
	output isgd_pkg::mid_t     mid_data,
	input  logic               mid_pop
);

	localparam int CntW = $clog2(QueueDepth + 1);

	logic [CntW-1:0] credit_q;
	logic            accept;

	// Stage 1: squares
	logic               valid_s1;
	logic signed [15:0] ax_s1, gx_s1, gy_s1, gz_s1;
	logic        [30:0] sqx_s1, sqy_s1, sqz_s1;
	logic signed [31:0] sqx, sqy, sqz;

	// Stage 2: magnitude
	logic               valid_s2;
	logic signed [15:0] ax_s2, gx_s2, gy_s2, gz_s2;
	logic        [31:0] mag_s2;

	// State machine
	isgd_pkg::mode_t mode_q, mode_d, gest;
	logic [31:0]     peak_q, peak_d, peak_cand;

	logic signed [16:0] gx_ext, gy_ext, gz_ext;
	logic        [16:0] gx_abs;
	logic signed [16:0] gz_trig_s, gy_trig_s, gx_lim_s;
	logic signed [17:0] gz_diff, gx_diff;
	logic        [17:0] gz_dabs, gx_dabs;
	logic               big, swing_ok, down_hit, up_hit, mute_hit, gz_rel, gx_rel;

	assign accept = push & ~full;
	assign full   = (credit_q == CntW'(QueueDepth));

	// Credit counts items in the two stages and in the queue behind them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({accept, mid_pop})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	assign sqx = gyro_x * gyro_x;
	assign sqy = gyro_y * gyro_y;
	assign sqz = gyro_z * gyro_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1  <= accel_x;
		gx_s1  <= gyro_x;
		gy_s1  <= gyro_y;
		gz_s1  <= gyro_z;
		sqx_s1 <= sqx[30:0];
		sqy_s1 <= sqy[30:0];
		sqz_s1 <= sqz[30:0];
		ax_s2  <= ax_s1;
		gx_s2  <= gx_s1;
		gy_s2  <= gy_s1;
		gz_s2  <= gz_s1;
		// three squares of at most 2^30 never reach 2^32, so no saturation
		mag_s2 <= {1'b0, sqx_s1} + {1'b0, sqy_s1} + {1'b0, sqz_s1};
	end

	// Threshold tests
	assign gx_ext    = {gx_s2[15], gx_s2};
	assign gy_ext    = {gy_s2[15], gy_s2};
	assign gz_ext    = {gz_s2[15], gz_s2};
	assign gx_abs    = gx_s2[15] ? 17'(-gx_ext) : 17'(gx_ext);
	assign gz_trig_s = $signed({2'b00, cfg.gz_trigger});
	assign gy_trig_s = $signed({2'b00, cfg.gy_trigger});
	assign gx_lim_s  = $signed({2'b00, cfg.gx_limit});

	assign big      = mag_s2 > cfg.magnitude_threshold;
	assign swing_ok = big && (gx_abs < {2'b00, cfg.gx_limit}) && (ax_s2 > cfg.ax_floor);
	assign down_hit = (gz_ext < -gz_trig_s) && (gy_ext > gy_trig_s);
	assign up_hit   = (gz_ext > gz_trig_s) && (gy_ext < -gy_trig_s);
	assign mute_hit = big && (gx_ext > (gx_lim_s + isgd_pkg::MuteGxExtra))
		&& (gz_s2 < isgd_pkg::MuteGzCeil);

	// Distance from bias, exact in 18 bits
	assign gz_diff = {{2{gz_s2[15]}}, gz_s2} - {{2{cfg.gz_bias[15]}}, cfg.gz_bias};
	assign gx_diff = {{2{gx_s2[15]}}, gx_s2} - {{2{cfg.gx_bias[15]}}, cfg.gx_bias};
	assign gz_dabs = gz_diff[17] ? 18'(-gz_diff) : 18'(gz_diff);
	assign gx_dabs = gx_diff[17] ? 18'(-gx_diff) : 18'(gx_diff);
	assign gz_rel  = gz_dabs < {2'b00, cfg.release_band};
	assign gx_rel  = gx_dabs < {2'b00, cfg.release_band};

	assign peak_cand = ((mode_q != isgd_pkg::MODE_IDLE) && (mag_s2 > peak_q)) ? mag_s2 : peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= isgd_pkg::MODE_IDLE;
			peak_q <= '0;
		end else if (valid_s2) begin
			mode_q <= mode_d;
			peak_q <= peak_d;
		end
	end

	always_comb begin
		mode_d = mode_q;
		peak_d = peak_cand;
		gest   = isgd_pkg::MODE_IDLE;
		unique case (mode_q)
			isgd_pkg::MODE_IDLE: begin
				if (swing_ok) begin
					if (down_hit) begin
						mode_d = isgd_pkg::MODE_DOWN;
						peak_d = mag_s2;
					end else if (up_hit) begin
						mode_d = isgd_pkg::MODE_UP;
						peak_d = mag_s2;
					end
				end else if (mute_hit) begin
					mode_d = isgd_pkg::MODE_MUTE;
				end
			end
			isgd_pkg::MODE_DOWN, isgd_pkg::MODE_UP: begin
				if (gz_rel) begin
					gest   = mode_q;
					mode_d = isgd_pkg::MODE_IDLE;
					peak_d = '0;
				end
			end
			isgd_pkg::MODE_MUTE: begin
				if (gx_rel) begin
					gest   = isgd_pkg::MODE_MUTE;
					mode_d = isgd_pkg::MODE_IDLE;
					peak_d = '0;
				end
			end
		endcase
	end

	assign mid_push         = valid_s2;
	assign mid_data.gesture = gest;
	assign mid_data.peak    = peak_cand;

endmodule

FILE: src/isgd_back.sv
// Back end: maps the swing peak to a 0-127 velocity and forms the result.
module isgd_back #(
	parameter int OutDepth = isgd_pkg::OutDepthDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mid_empty,
	input  isgd_pkg::mid_t mid_data,
	output logic           mid_pop,
	output logic           out_push,
	output isgd_pkg::res_t out_data,
	input  logic           out_pop
);

	localparam int CntW = $clog2(OutDepth + 1);

	logic [CntW-1:0] credit_q;

	logic [31:0] d_full;
	logic [47:0] prod;

	logic            valid_v1;
	isgd_pkg::mode_t gest_v1;
	logic            lo_v1, hi_v1;
	logic [30:0]     d_v1;
	logic [47:0]     prod_v1;

	logic [6:0]      est;
	logic [7:0]      est_inc;

	logic            valid_v2;
	isgd_pkg::mode_t gest_v2;
	logic            lo_v2, hi_v2;
	logic [6:0]      e_v2;
	logic [38:0]     t_v2;
	logic [37:0]     d127_v2;

	logic            swing;
	logic [6:0]      vel_c;

	// Credit covers both stages and the result queue
	assign mid_pop = ~mid_empty && (credit_q < CntW'(OutDepth));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({mid_pop, out_pop})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	// Stage 1: offset and reciprocal estimate
	assign d_full = mid_data.peak - isgd_pkg::VelMinMag;
	assign prod   = 48'(d_full[30:0]) * 48'(isgd_pkg::VelRecip);

	// Stage 2: check product for the estimate plus one
	assign est     = prod_v1[isgd_pkg::VelShift+6:isgd_pkg::VelShift];
	assign est_inc = {1'b0, est} + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_v1 <= 1'b0;
			valid_v2 <= 1'b0;
		end else begin
			valid_v1 <= mid_pop;
			valid_v2 <= valid_v1;
		end
	end

	always_ff @(posedge clk) begin
		gest_v1 <= mid_data.gesture;
		lo_v1   <= mid_data.peak <= isgd_pkg::VelMinMag;
		hi_v1   <= mid_data.peak >= isgd_pkg::VelMaxMag;
		d_v1    <= d_full[30:0];
		prod_v1 <= prod;
		gest_v2 <= gest_v1;
		lo_v2   <= lo_v1;
		hi_v2   <= hi_v1;
		e_v2    <= est;
		t_v2    <= 39'(est_inc) * 39'(isgd_pkg::VelSpan);
		d127_v2 <= (38'(d_v1) << 7) - 38'(d_v1);
	end

	// Correct the estimate and clamp
	assign swing = (gest_v2 == isgd_pkg::MODE_DOWN) || (gest_v2 == isgd_pkg::MODE_UP);

	always_comb begin
		vel_c = (t_v2 <= {1'b0, d127_v2}) ? e_v2 + 7'd1 : e_v2;
		if (!swing || lo_v2) begin
			vel_c = '0;
		end else if (hi_v2) begin
			vel_c = isgd_pkg::VelTop;
		end
	end

	assign out_push          = valid_v2;
	assign out_data.gesture  = gest_v2;
	assign out_data.velocity = vel_c;

endmodule

FILE: tb/imu_strum_gesture_detector_top_tb.sv
// Testbench of the IMU strum gesture detector: directed table, gesture sequences, live prediction.
`timescale 1ns / 1ps

module imu_strum_gesture_detector_top_tb;

	// Palm mute arming margins, as the block's behavior defines them, and the drain wait
	localparam int     MuteGxMargin  = 3500;
	localparam int     MuteGzCeiling = 5000;
	localparam int     DrainCycles   = 12;
	localparam int     PhaseItems    = 125;
	localparam longint MagCeiling    = 64'h0000_0000_FFFF_FFFF;

	// One row of the directed table; chk marks rows whose result is typed in here
	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] gx;
		logic signed [15:0] gy;
		logic signed [15:0] gz;
		logic               chk;
		logic        [1:0]  g;
		logic        [6:0]  v;
	} sample_row_t;

	// Directed samples, taken with the register defaults in force
	localparam sample_row_t DIR_ROWS [19] = '{
		// all zero right after reset: nothing happens
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 2'd0, 7'd0},
		// arm a down swing at the field extremes
		'{16'sh7FFF, 16'sd0, 16'sh7FFF, 16'sh8000, 1'b1, 2'd0, 7'd0},
		// largest possible magnitude while armed: peak tracks it
		'{16'sd0, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 2'd0, 7'd0},
		// gyro Z back at its bias: down strum at full velocity
		'{16'sd0, 16'sd0, 16'sd0, 16'sd416, 1'b1, 2'd1, 7'd127},
		// arm an up swing with a peak right at the low end of the velocity map
		'{16'sd0, 16'sd0, -16'sd20000, 16'sd20000, 1'b0, 2'd0, 7'd0},
		// release one inside the band edge: up strum, velocity zero
		'{16'sd0, 16'sd0, 16'sd0, 16'sd4415, 1'b1, 2'd2, 7'd0},
		// gyro X far past the limit: arm a palm mute
		'{16'sd0, 16'sd30000, 16'sd0, 16'sd0, 1'b0, 2'd0, 7'd0},
		// gyro X exactly one band away from its bias: hold the mute
		'{16'sd0, 16'sd3000, 16'sd0, 16'sd0, 1'b0, 2'd0, 7'd0},
		// one inside the band: palm mute reported, other fields ignored
		'{16'sh8000, 16'sd2999, 16'sh7FFF, 16'sh7FFF, 1'b1, 2'd3, 7'd0},
		// accel X at the floor: no swing
		'{-16'sd6000, 16'sd0, 16'sd20000, -16'sd20000, 1'b0, 2'd0, 7'd0},
		// swing test holds but no direction matches: stay idle, mute not tried
		'{16'sd0, 16'sd0, 16'sd30000, 16'sd30000, 1'b0, 2'd0, 7'd0},
		// most negative gyro X fails both tests
		'{16'sd0, 16'sh8000, 16'sd20000, -16'sd20000, 1'b0, 2'd0, 7'd0},
		// gyro X just under the limit: down swing with a mid-range peak
		'{16'sd0, 16'sd19999, 16'sd25000, -16'sd25000, 1'b0, 2'd0, 7'd0},
		// gyro Z exactly one band below its bias: hold
		'{16'sd0, 16'sd0, 16'sd0, -16'sd3584, 1'b0, 2'd0, 7'd0},
		// one inside the band: down strum with a mapped velocity
		'{16'sd0, 16'sd0, 16'sd0, -16'sd3583, 1'b0, 2'd0, 7'd0},
		// mute arming at its margins
		'{16'sd0, 16'sd23501, 16'sd15000, 16'sd4999, 1'b0, 2'd0, 7'd0},
		// gyro X exactly at its bias: palm mute
		'{16'sd0, -16'sd1000, 16'sd0, 16'sd0, 1'b1, 2'd3, 7'd0},
		// every field at its top: neither test passes
		'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 2'd0, 7'd0},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 2'd0, 7'd0}
	};

	logic                          clk             = 1'b0;
	logic                          arst_n          = 1'b0;
	logic                          push            = 1'b0;
	logic signed [15:0]            accel_x         = '0;
	logic signed [15:0]            gyro_x          = '0;
	logic signed [15:0]            gyro_y          = '0;
	logic signed [15:0]            gyro_z          = '0;
	logic                          pop             = 1'b0;
	logic                          psel            = 1'b0;
	logic                          penable         = 1'b0;
	logic                          pwrite          = 1'b0;
	logic [isgd_pkg::CfgAddrW-1:0] paddr           = '0;
	logic [isgd_pkg::CfgDataW-1:0] pwdata          = '0;
	logic                          full;
	logic                          empty;
	logic [1:0]                    gesture;
	logic [6:0]                    strike_velocity;
	logic [isgd_pkg::CfgDataW-1:0] prdata;
	logic                          pready;

	// Shadow of the gesture machine and its registers
	isgd_pkg::cfg_t  cfg_now;
	isgd_pkg::mode_t gest_mode;
	logic [31:0]     gest_peak;

	// Results owed by the block, oldest first
	isgd_pkg::res_t gesture_due[$];

	int   fail_count    = 0;
	int   phase_items   = 0;
	int   burst_left    = 0;
	bit   steady_sender = 1'b0;

	// Receiver stall pattern, replaced each time the slot counter wraps
	logic [15:0] pop_pattern = '0;
	logic [3:0]  pop_slot    = '0;
	int          pop_roll;

	imu_strum_gesture_detector_top uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.accel_x         (accel_x),
		.gyro_x          (gyro_x),
		.gyro_y          (gyro_y),
		.gyro_z          (gyro_z),
		.empty           (empty),
		.pop             (pop),
		.gesture         (gesture),
		.strike_velocity (strike_velocity),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int abs_int(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic signed [15:0] any_s16();
		return 16'($urandom());
	endfunction

	// Draw a value in [lo, hi] clipped to the 16-bit range; an empty span draws anything
	function automatic logic signed [15:0] pick_between(input int lo, input int hi);
		if (lo < -32768)
			lo = -32768;
		if (hi > 32767)
			hi = 32767;
		if (lo > hi)
			return any_s16();
		return 16'(lo + int'($urandom_range(hi - lo)));
	endfunction

	// Linear map of the swing peak onto 0..127
	function automatic logic [6:0] velocity_from_peak(input logic [31:0] peak);
		longint unsigned scaled;
		if (peak <= 32'd800000000)
			return 7'd0;
		if (peak >= 32'd2500000000)
			return 7'd127;
		scaled = (64'(peak) - 64'd800000000) * 64'd127 / 64'd1700000000;
		return scaled[6:0];
	endfunction

	// Advance the shadow machine by one sample and return the result it owes
	function automatic isgd_pkg::res_t track_gesture(input logic signed [15:0] ax, gx, gy, gz);
		int             a, x, y, z, lim, flr, z_trig, y_trig, band, z_bias, x_bias;
		longint         mag;
		bit             big;
		isgd_pkg::res_t r;
		a      = ax;
		x      = gx;
		y      = gy;
		z      = gz;
		lim    = int'(cfg_now.gx_limit);
		flr    = int'($signed(cfg_now.ax_floor));
		z_trig = int'(cfg_now.gz_trigger);
		y_trig = int'(cfg_now.gy_trigger);
		band   = int'(cfg_now.release_band);
		z_bias = int'($signed(cfg_now.gz_bias));
		x_bias = int'($signed(cfg_now.gx_bias));
		mag    = longint'(x) * x + longint'(y) * y + longint'(z) * z;
		if (mag > MagCeiling)
			mag = MagCeiling;
		big = mag > longint'(cfg_now.magnitude_threshold);
		r   = '0;

		// The peak includes the current sample whenever something is armed
		if (gest_mode != isgd_pkg::MODE_IDLE && mag > longint'(gest_peak))
			gest_peak = mag[31:0];

		case (gest_mode)
			isgd_pkg::MODE_IDLE: begin
				if (big && abs_int(x) < lim && a > flr) begin
					if (z < -z_trig && y > y_trig) begin
						gest_mode = isgd_pkg::MODE_DOWN;
						gest_peak = mag[31:0];
					end else if (z > z_trig && y < -y_trig) begin
						gest_mode = isgd_pkg::MODE_UP;
						gest_peak = mag[31:0];
					end
				end else if (big && x > lim + MuteGxMargin && z < MuteGzCeiling) begin
					gest_mode = isgd_pkg::MODE_MUTE;
				end
			end
			isgd_pkg::MODE_DOWN, isgd_pkg::MODE_UP: begin
				// Bias difference taken in full precision, no wrap
				if (abs_int(z - z_bias) < band) begin
					r.gesture  = gest_mode;
					r.velocity = velocity_from_peak(gest_peak);
					gest_mode  = isgd_pkg::MODE_IDLE;
					gest_peak  = '0;
				end
			end
			default: begin
				if (abs_int(x - x_bias) < band) begin
					r.gesture = isgd_pkg::MODE_MUTE;
					gest_mode = isgd_pkg::MODE_IDLE;
					gest_peak = '0;
				end
			end
		endcase
		return r;
	endfunction

	// Offer one sample; on acceptance, log what the block owes for it, then maybe pause
	task automatic offer_sample(input logic signed [15:0] ax, gx, gy, gz,
			input logic typed, input isgd_pkg::res_t want);
		isgd_pkg::res_t owed;
		int             gap;
		@(negedge clk);
		push    <= 1'b1;
		accel_x <= ax;
		gyro_x  <= gx;
		gyro_y  <= gy;
		gyro_z  <= gz;
		@(posedge clk);
		while (full)
			@(posedge clk);
		owed = track_gesture(ax, gx, gy, gz);
		gesture_due.push_back(typed ? want : owed);
		phase_items++;

		// Bursts of back-to-back transactions separated by random gaps unless the sender is steady
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady_sender ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				push <= 1'b0;
				repeat (gap - 1)
					@(negedge clk);
			end
		end
	endtask

	// One APB write: setup, access, land on the edge with pready high
	task automatic write_reg(input isgd_pkg::reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			isgd_pkg::REG_MAG_THRESH:   cfg_now.magnitude_threshold = value;
			isgd_pkg::REG_GX_LIMIT:     cfg_now.gx_limit            = value[14:0];
			isgd_pkg::REG_AX_FLOOR:     cfg_now.ax_floor            = value[15:0];
			isgd_pkg::REG_GZ_TRIGGER:   cfg_now.gz_trigger          = value[14:0];
			isgd_pkg::REG_GY_TRIGGER:   cfg_now.gy_trigger          = value[14:0];
			isgd_pkg::REG_RELEASE_BAND: cfg_now.release_band        = value[15:0];
			isgd_pkg::REG_GZ_BIAS:      cfg_now.gz_bias             = value[15:0];
			isgd_pkg::REG_GX_BIAS:      cfg_now.gx_bias             = value[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Load a full register set; unused upper data bits carry junk the block must drop
	task automatic apply_setting(input isgd_pkg::cfg_t s);
		logic [31:0] junk;
		junk = $urandom();
		write_reg(isgd_pkg::REG_MAG_THRESH, s.magnitude_threshold);
		write_reg(isgd_pkg::REG_GX_LIMIT, {junk[31:15], s.gx_limit});
		write_reg(isgd_pkg::REG_AX_FLOOR, {junk[31:16], s.ax_floor});
		write_reg(isgd_pkg::REG_GZ_TRIGGER, {junk[30:14], s.gz_trigger});
		write_reg(isgd_pkg::REG_GY_TRIGGER, {junk[29:13], s.gy_trigger});
		write_reg(isgd_pkg::REG_RELEASE_BAND, {junk[27:12], s.release_band});
		write_reg(isgd_pkg::REG_GZ_BIAS, {junk[26:11], s.gz_bias});
		write_reg(isgd_pkg::REG_GX_BIAS, {junk[25:10], s.gx_bias});
	endtask

	// Drop push and wait until every owed result is out and the pipe is quiet
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (gesture_due.size() != 0)
			@(posedge clk);
		repeat (DrainCycles)
			@(posedge clk);
	endtask

	// One gesture attempt with random content: arm, track, release; or a bit of noise
	task automatic play_gesture();
		int                 kind, lim, flr, z_trig, y_trig, band, z_bias, x_bias;
		logic signed [15:0] ax, gx, gy, gz;
		isgd_pkg::res_t     blank;
		blank  = '0;
		lim    = int'(cfg_now.gx_limit);
		flr    = int'($signed(cfg_now.ax_floor));
		z_trig = int'(cfg_now.gz_trigger);
		y_trig = int'(cfg_now.gy_trigger);
		band   = int'(cfg_now.release_band);
		z_bias = int'($signed(cfg_now.gz_bias));
		x_bias = int'($signed(cfg_now.gx_bias));
		kind   = $urandom_range(0, 9);

		if (kind >= 8) begin
			repeat ($urandom_range(1, 3))
				offer_sample(any_s16(), any_s16(), any_s16(), any_s16(), 1'b0, blank);
			return;
		end

		// Arming sample aimed at the chosen gesture
		ax = pick_between(flr + 1, 32767);
		if (kind < 3) begin
			gx = pick_between(1 - lim, lim - 1);
			gy = pick_between(y_trig + 1, 32767);
			gz = pick_between(-32768, -z_trig - 1);
		end else if (kind < 6) begin
			gx = pick_between(1 - lim, lim - 1);
			gy = pick_between(-32768, -y_trig - 1);
			gz = pick_between(z_trig + 1, 32767);
		end else begin
			gx = pick_between(lim + MuteGxMargin + 1, 32767);
			gy = any_s16();
			gz = pick_between(-32768, MuteGzCeiling - 1);
		end
		offer_sample(ax, gx, gy, gz, 1'b0, blank);

		// Tracking samples; some of them release by chance
		repeat ($urandom_range(0, 4))
			offer_sample(any_s16(), any_s16(), any_s16(), any_s16(), 1'b0, blank);

		// Release near the matching bias, band edges included; skip it now and then
		if ($urandom_range(0, 99) < 85) begin
			if (kind < 6)
				offer_sample(any_s16(), any_s16(), any_s16(),
					pick_between(z_bias - band, z_bias + band), 1'b0, blank);
			else
				offer_sample(any_s16(), pick_between(x_bias - band, x_bias + band),
					any_s16(), any_s16(), 1'b0, blank);
		end
	endtask

	// Receiver: pop on a pattern of its own, with full-rate and fully stalled windows
	always @(negedge clk) begin
		if (pop_slot == 4'd0) begin
			pop_roll = $urandom_range(0, 19);
			if (pop_roll < 5)
				pop_pattern = '1;
			else if (pop_roll < 7)
				pop_pattern = '0;
			else
				pop_pattern = 16'($urandom());
		end
		pop      <= pop_pattern[pop_slot];
		pop_slot = pop_slot + 4'd1;
	end

	// Check every result transaction against the oldest owed result
	always @(posedge clk) begin
		isgd_pkg::res_t want;
		if (arst_n && pop && !empty) begin
			if (gesture_due.size() == 0) begin
				fail_count++;
				$error("unexpected result: gesture %0d strike_velocity %0d",
					gesture, strike_velocity);
			end else begin
				want = gesture_due.pop_front();
				if (gesture !== want.gesture) begin
					fail_count++;
					$error("gesture: expected %0d, got %0d", want.gesture, gesture);
				end
				if (strike_velocity !== want.velocity) begin
					fail_count++;
					$error("strike_velocity: expected %0d, got %0d",
						want.velocity, strike_velocity);
				end
			end
		end
	end

	// Stimulus: reset, directed table, then phases of gesture sequences under the defaults and new settings
	initial begin
		sample_row_t    row;
		isgd_pkg::res_t want;
		isgd_pkg::cfg_t s;

		cfg_now   = '{32'd650000000, 15'd20000, -16'sd6000, 15'd10000, 15'd5000,
			16'd4000, 16'sd416, -16'sd1000};
		gest_mode = isgd_pkg::MODE_IDLE;
		gest_peak = '0;

		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table; typed rows owe the value written in the row
		for (int k = 0; k < $size(DIR_ROWS); k++) begin
			row           = DIR_ROWS[k];
			want.gesture  = row.g;
			want.velocity = row.v;
			offer_sample(row.ax, row.gx, row.gy, row.gz, row.chk, want);
		end

		for (int p = 0; p < 6; p++) begin
			settle();
			s = cfg_now;
			case (p)
				0: ;  // stay on the defaults
				1: begin
					// moderate settings under which gestures arm and release often
					s.magnitude_threshold = $urandom_range(0, 1500000000);
					s.gx_limit            = 15'($urandom_range(0, 32767));
					s.ax_floor            = pick_between(-32768, 5000);
					s.gz_trigger          = 15'($urandom_range(0, 20000));
					s.gy_trigger          = 15'($urandom_range(0, 20000));
					s.release_band        = 16'($urandom_range(0, 12000));
					s.gz_bias             = pick_between(-3000, 3000);
					s.gx_bias             = pick_between(-3000, 3000);
				end
				2: s = '{32'hFFFF_FFFF, 15'h0000, 16'sh7FFF, 15'h7FFF, 15'h7FFF,
					16'h0000, 16'sh7FFF, 16'sh8000};
				3: s = '{32'h0000_0000, 15'h7FFF, 16'sh8000, 15'h0000, 15'h0000,
					16'hFFFF, 16'sh8000, 16'sh7FFF};
				4: begin
					s.magnitude_threshold = $urandom();
					s.gx_limit            = 15'($urandom());
					s.ax_floor            = 16'($urandom());
					s.gz_trigger          = 15'($urandom());
					s.gy_trigger          = 15'($urandom());
					s.release_band        = 16'($urandom());
					s.gz_bias             = 16'($urandom());
					s.gx_bias             = 16'($urandom());
				end
				default: s = '{32'd650000000, 15'd20000, -16'sd6000, 15'd10000,
					15'd5000, 16'd4000, 16'sd416, -16'sd1000};
			endcase
			if (p != 0)
				apply_setting(s);

			// Some phases run the sender flat out
			steady_sender = ($urandom_range(0, 3) == 0);
			phase_items   = 0;
			while (phase_items < PhaseItems)
				play_gesture();
		end

		steady_sender = 1'b0;
		settle();
		if (fail_count == 0)
			$display("imu_strum_gesture_detector_top_tb: PASS");
		else
			$display("imu_strum_gesture_detector_top_tb: FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#5_000_000;
		$display("imu_strum_gesture_detector_top_tb: FAIL");
		$finish;
	end

endmodule
